>>> rtl/psc_pkg.sv
// psc_pkg: shared types, codes and the command frame builder for the
// priority sound command scheduler; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package psc_pkg;

  // request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_PLAY   = 2'd1,
    REQ_VOLUME = 2'd2,
    REQ_INIT   = 2'd3
  } req_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_GAP     = 2'd0,
    CFG_TIMEOUT = 2'd1,
    CFG_DEFVOL  = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_e;

  // frame layout and command codes
  localparam logic [7:0] FR_START   = 8'h7E;
  localparam logic [7:0] FR_VERSION = 8'hFF;
  localparam logic [7:0] FR_LENGTH  = 8'h06;
  localparam logic [7:0] FR_FEEDBK  = 8'h00;
  localparam logic [7:0] FR_END     = 8'hEF;
  localparam logic [7:0] CMD_PLAY   = 8'h03;
  localparam logic [7:0] CMD_VOLUME = 8'h06;
  localparam logic [7:0] CMD_RESET  = 8'h0C;
  localparam logic [7:0] MAX_VOL    = 8'd30;

  localparam int FRAME_LEN = 10;
  localparam int RUN_IDX_W = 5;
  localparam logic [RUN_IDX_W-1:0] LAST_ONE = RUN_IDX_W'(FRAME_LEN - 1);
  localparam logic [RUN_IDX_W-1:0] LAST_TWO = RUN_IDX_W'(2 * FRAME_LEN - 1);
  localparam logic [RUN_IDX_W-1:0] SECOND_START = RUN_IDX_W'(FRAME_LEN);

  // configuration reset values
  localparam logic [15:0] GAP_RESET     = 16'd100;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [4:0]  DEFVOL_RESET  = 5'd20;

  // description of the results caused by one request beat
  typedef struct packed {
    logic [1:0] nframes;   // 0 status only, 1 or 2 frames
    logic [7:0] cmd_a;     // first frame command
    logic [7:0] p2_a;      // first frame second parameter
    logic [7:0] p2_b;      // second frame (always volume) parameter
    logic       playing;   // playing flag after the request
  } run_t;

  // byte at position pos of a frame; parameter 1 is always zero
  function automatic logic [7:0] frame_byte_at(input logic [7:0] cmd,
                                               input logic [7:0] p2,
                                               input logic [3:0] pos);
    logic [15:0] sum;
    logic [15:0] chk;
    logic [7:0]  b;
    sum = 16'(FR_VERSION) + 16'(FR_LENGTH) + 16'(cmd) + 16'(p2);
    chk = 16'(0) - sum;
    case (pos)
      4'd0: b = FR_START;
      4'd1: b = FR_VERSION;
      4'd2: b = FR_LENGTH;
      4'd3: b = cmd;
      4'd4: b = FR_FEEDBK;
      4'd5: b = 8'h00;
      4'd6: b = p2;
      4'd7: b = chk[15:8];
      4'd8: b = chk[7:0];
      4'd9: b = FR_END;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/psc_ifs.sv
// psc_req_if / psc_res_if: valid-ready channels of the scheduler
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface psc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] sound_track;
  logic [1:0] request_priority;
  logic [7:0] volume_level;

  modport source (output valid, req_type, sound_track, request_priority, volume_level,
                  input ready);
  modport sink (input valid, req_type, sound_track, request_priority, volume_level,
                output ready);
endinterface

interface psc_res_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] frame_byte;
  logic       last_of_run;
  logic       is_playing;

  modport source (output valid, byte_valid, frame_byte, last_of_run, is_playing,
                  input ready);
  modport sink (input valid, byte_valid, frame_byte, last_of_run, is_playing,
                output ready);
endinterface
`default_nettype wire

>>> rtl/psc_frame_ser.sv
// psc_frame_ser: holds one run description and plays it out as result beats
// depends on psc_pkg and psc_res_if
`timescale 1ns / 1ps
`default_nettype none
module psc_frame_ser (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         desc_valid,
  output logic              desc_ready,
  input  psc_pkg::run_t     desc,
  psc_res_if.source         res
);
  import psc_pkg::*;

  logic                 run_valid;
  run_t                 run;
  logic [RUN_IDX_W-1:0] idx;
  logic                 out_load;
  logic                 is_last;
  logic                 in_second;
  logic [3:0]           pos_full;
  logic [7:0]           byte_next;

  // position within the run
  always_comb begin
    in_second = (idx >= SECOND_START);
    pos_full  = in_second ? 4'(idx - SECOND_START) : idx[3:0];
    case (run.nframes)
      2'd0:    is_last = 1'b1;
      2'd1:    is_last = (idx == LAST_ONE);
      2'd2:    is_last = (idx == LAST_TWO);
      default: is_last = 1'b1;
    endcase
    if (run.nframes == 2'd0) begin
      byte_next = 8'h00;
    end else if (in_second) begin
      byte_next = frame_byte_at(CMD_VOLUME, run.p2_b, pos_full);
    end else begin
      byte_next = frame_byte_at(run.cmd_a, run.p2_a, pos_full);
    end
  end

  assign out_load   = run_valid && (!res.valid || res.ready);
  assign desc_ready = !run_valid || (out_load && is_last);

  // run register and byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_load) begin
        idx <= is_last ? '0 : idx + 1'b1;
      end
      if (desc_valid && desc_ready) begin
        run_valid <= 1'b1;
      end else if (out_load && is_last) begin
        run_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_valid && desc_ready) begin
      run <= desc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.byte_valid  <= (run.nframes != 2'd0);
      res.frame_byte  <= byte_next;
      res.last_of_run <= is_last;
      res.is_playing  <= run.playing;
    end
  end

  // a status-only beat always closes its run
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.byte_valid |-> res.last_of_run)
    else $error("status beat without last_of_run");

  // index never runs past a two-frame run
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= LAST_TWO)
    else $error("run index out of range");

  // an idle serializer keeps its index at the start
  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    !run_valid |-> idx == '0)
    else $error("index not cleared when idle");

endmodule
`default_nettype wire

>>> rtl/priority_sound_command_scheduler_top.sv
// priority_sound_command_scheduler_top: request decode, scheduler state and
// configuration; depends on psc_pkg, psc_ifs and psc_frame_ser
//
// Usage: request beats (tick, play, set volume, init) arrive on req; each
// beat causes a run of result beats on res: one status beat when no frame is
// sent, ten frame bytes for a play or volume command, twenty for init (reset
// frame then volume frame). last_of_run marks the final beat of each run.
// The state is updated in the cycle a request is taken; its run description
// sits in a one-entry run register and is played out one beat per cycle,
// while the receiver takes beats, through a result register; the first
// result beat passes the run register and then the result register.
// Throughput: one request per cycle while runs are single status beats and
// the receiver keeps up; a frame run holds the run register until its 10 or
// 20 beats are loaded. req.ready is high whenever the run register is free
// or its last beat is being loaded into the result register.
// Reset clears all flags, both tick counters and the pending slot, and loads
// the configuration defaults (gap 100, timeout 5000, volume 20).
// A stalled receiver holds the result register; the run register then
// fills and req.ready drops until beats drain.
`timescale 1ns / 1ps
`default_nettype none
module priority_sound_command_scheduler_top #(
  parameter int TICK_COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  psc_req_if.sink          req,
  psc_res_if.source        res
);
  import psc_pkg::*;

  localparam int CMP_W = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;

  // configuration
  logic [15:0] command_gap_ticks;
  logic [15:0] play_timeout_ticks;
  logic [4:0]  default_volume;

  // scheduler state
  logic       ready_flag, ready_flag_next;
  logic       playing_flag, playing_flag_next;
  logic [1:0] current_priority, current_priority_next;
  logic       pending_flag, pending_flag_next;
  logic [7:0] pending_track, pending_track_next;
  logic [1:0] pending_priority, pending_priority_next;
  logic [TICK_COUNT_BITS-1:0] since_command, since_command_next;
  logic [TICK_COUNT_BITS-1:0] since_play_start, since_play_start_next;

  logic                       accept;
  logic                       desc_ready;
  run_t                       desc;
  req_e                       kind;
  logic [TICK_COUNT_BITS-1:0] sc_inc, sp_inc;
  logic [7:0]                 vol_clamped;
  logic [7:0]                 defvol_clamped;

  assign accept    = req.valid && req.ready;
  assign req.ready = desc_ready;
  assign kind      = req_e'(req.req_type);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      command_gap_ticks  <= GAP_RESET;
      play_timeout_ticks <= TIMEOUT_RESET;
      default_volume     <= DEFVOL_RESET;
    end else if (cfg_we) begin
      case (cfg_e'(cfg_index))
        CFG_GAP:     command_gap_ticks  <= cfg_data;
        CFG_TIMEOUT: play_timeout_ticks <= cfg_data;
        CFG_DEFVOL:  default_volume     <= cfg_data[4:0];
        default:     ;
      endcase
    end
  end

  // saturating counters and clamps
  always_comb begin
    sc_inc = (&since_command) ? since_command : since_command + 1'b1;
    sp_inc = (&since_play_start) ? since_play_start : since_play_start + 1'b1;
    vol_clamped    = (req.volume_level > MAX_VOL) ? MAX_VOL : req.volume_level;
    defvol_clamped = (8'(default_volume) > MAX_VOL) ? MAX_VOL : 8'(default_volume);
  end

  // next state and run description
  always_comb begin
    ready_flag_next       = ready_flag;
    playing_flag_next     = playing_flag;
    current_priority_next = current_priority;
    pending_flag_next     = pending_flag;
    pending_track_next    = pending_track;
    pending_priority_next = pending_priority;
    since_command_next    = since_command;
    since_play_start_next = since_play_start;
    desc.nframes = 2'd0;
    desc.cmd_a   = CMD_PLAY;
    desc.p2_a    = 8'h00;
    desc.p2_b    = defvol_clamped;
    case (kind)
      REQ_TICK: begin
        since_command_next    = sc_inc;
        since_play_start_next = sp_inc;
        if (ready_flag) begin
          if (playing_flag && (CMP_W'(sp_inc) >= CMP_W'(play_timeout_ticks))) begin
            playing_flag_next     = 1'b0;
            current_priority_next = 2'd0;
          end
          if (pending_flag && (CMP_W'(sc_inc) >= CMP_W'(command_gap_ticks))) begin
            desc.nframes          = 2'd1;
            desc.cmd_a            = CMD_PLAY;
            desc.p2_a             = pending_track;
            playing_flag_next     = 1'b1;
            current_priority_next = pending_priority;
            since_play_start_next = '0;
            since_command_next    = '0;
            pending_flag_next     = 1'b0;
          end
        end
      end
      REQ_PLAY: begin
        if (ready_flag && (!playing_flag || req.request_priority >= current_priority)) begin
          pending_track_next    = req.sound_track;
          pending_priority_next = req.request_priority;
          pending_flag_next     = 1'b1;
        end
      end
      REQ_VOLUME: begin
        if (ready_flag) begin
          desc.nframes       = 2'd1;
          desc.cmd_a         = CMD_VOLUME;
          desc.p2_a          = vol_clamped;
          since_command_next = '0;
        end
      end
      default: begin
        desc.nframes          = 2'd2;
        desc.cmd_a            = CMD_RESET;
        desc.p2_a             = 8'h00;
        ready_flag_next       = 1'b1;
        playing_flag_next     = 1'b0;
        current_priority_next = 2'd0;
        since_command_next    = '0;
      end
    endcase
    desc.playing = playing_flag_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_flag       <= 1'b0;
      playing_flag     <= 1'b0;
      current_priority <= 2'd0;
      pending_flag     <= 1'b0;
      pending_track    <= 8'h00;
      pending_priority <= 2'd0;
      since_command    <= '0;
      since_play_start <= '0;
    end else if (accept) begin
      ready_flag       <= ready_flag_next;
      playing_flag     <= playing_flag_next;
      current_priority <= current_priority_next;
      pending_flag     <= pending_flag_next;
      pending_track    <= pending_track_next;
      pending_priority <= pending_priority_next;
      since_command    <= since_command_next;
      since_play_start <= since_play_start_next;
    end
  end

  psc_frame_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (req.valid),
    .desc_ready (desc_ready),
    .desc       (desc),
    .res        (res)
  );

  // nothing plays before init
  a_play_needs_init: assert property (@(posedge clk) disable iff (rst)
    !ready_flag |-> !playing_flag)
    else $error("playing before init");

  // init always leaves the block ready and silent
  a_init_effect: assert property (@(posedge clk) disable iff (rst)
    accept && kind == REQ_INIT |=> ready_flag && !playing_flag && since_command == '0)
    else $error("init did not take effect");

  // a play frame leaves the pending slot empty and playback started
  a_play_sent: assert property (@(posedge clk) disable iff (rst)
    accept && kind == REQ_TICK && desc.nframes == 2'd1 |=>
      !pending_flag && playing_flag && since_play_start == '0)
    else $error("play frame without state update");

endmodule
`default_nettype wire
